/* hdl/pmd_pkg.sv */
package pmd_pkg;

  localparam int POS_W      = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RESET_SCREEN_WIDTH  = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] RESET_SCREEN_HEIGHT = 13'd768;

  // header byte fields
  localparam logic [7:0] HDR_SYNC_BIT = 8'h08;
  localparam logic [7:0] HDR_OVERFLOW = 8'hC0;
  localparam logic [7:0] HDR_BUTTONS  = 8'h07;

  // event codes
  localparam logic [1:0] EV_MOVE = 2'd0;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [1:0] EV_UP   = 2'd2;

  localparam logic [1:0] BTN_NONE   = 2'd0;
  localparam logic [1:0] BTN_LEFT   = 2'd1;
  localparam logic [1:0] BTN_RIGHT  = 2'd2;
  localparam logic [1:0] BTN_MIDDLE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_aux;
  } pmd_in_t;

  typedef struct packed {
    logic [1:0]       event_type;
    logic [1:0]       button;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             last;
  } pmd_out_t;

  // events of one packet: mask bit 0 move, 1 left, 2 right, 3 middle
  typedef struct packed {
    logic [3:0]       mask;
    logic [2:0]       buttons;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
  } pmd_evset_t;

endpackage

/* hdl/pmd_evt_ser.sv */
module pmd_evt_ser import pmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load_valid,
  input  pmd_evset_t load,
  output logic       load_free,
  output logic       out_valid,
  input  logic       out_stall,
  output pmd_out_t   out_data
);

  logic [3:0]       mask;
  logic [2:0]       buttons;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  logic       out_open;
  logic       pop;
  logic [3:0] lowest;
  logic [3:0] rem;
  logic [3:0] mask_after;
  pmd_out_t   out_next;

  assign out_open   = !out_valid || !out_stall;
  assign pop        = (mask != 4'd0) && out_open;
  assign lowest     = mask & (~mask + 4'd1);
  assign rem        = mask & ~lowest;
  assign mask_after = pop ? rem : mask;
  assign load_free  = (mask_after == 4'd0);

  always_comb begin
    out_next.pos_x = pos_x;
    out_next.pos_y = pos_y;
    out_next.last  = (rem == 4'd0);
    out_next.event_type = EV_MOVE;
    out_next.button     = BTN_NONE;
    if (lowest[1]) begin
      out_next.button     = BTN_LEFT;
      out_next.event_type = buttons[0] ? EV_DOWN : EV_UP;
    end else if (lowest[2]) begin
      out_next.button     = BTN_RIGHT;
      out_next.event_type = buttons[1] ? EV_DOWN : EV_UP;
    end else if (lowest[3]) begin
      out_next.button     = BTN_MIDDLE;
      out_next.event_type = buttons[2] ? EV_DOWN : EV_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= 4'd0;
    end else if (load_valid && load_free) begin
      mask <= load.mask;
    end else begin
      mask <= mask_after;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_free) begin
      buttons <= load.buttons;
      pos_x   <= load.pos_x;
      pos_y   <= load.pos_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= out_next;
    end
  end

  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    (mask != 4'd0) && out_open |=> out_valid)
    else $error("pending event not moved to output");

  a_more_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> mask != 4'd0)
    else $error("non-final event shown with nothing left");

  a_load_taken: assert property (@(posedge clk) disable iff (rst)
    load_valid && load_free |=> mask == $past(load.mask))
    else $error("event set not captured");

endmodule

/* hdl/ps2_mouse_packet_decoder_core.sv */
// Path: an accepted byte is held in the input register and decoded from it, its events move
//   into the serializer's event mask register, and each event is then registered on out_data.
// Throughput: one byte per cycle; a completed packet yields up to four events, one per cycle
//   while out_stall is low, and the input stalls only while the event serializer still holds
//   undelivered events.
// Reset (rst, synchronous): decoding disabled, screen 1024 x 768, cursor centered, no events.
module ps2_mouse_packet_decoder_core import pmd_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pmd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pmd_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CB    = COORD_BITS;
  localparam int SW    = CB + 2;                            // signed cursor sum width
  localparam int CMP_W = (CB + 1 > CFG_DATA_W) ? CB + 1 : CFG_DATA_W;
  localparam int EXT_W = (CB > POS_W) ? CB : POS_W;

  // packet assembly positions
  localparam logic [1:0] BC_HEADER  = 2'd0;
  localparam logic [1:0] BC_DELTA_X = 2'd1;
  localparam logic [1:0] BC_DELTA_Y = 2'd2;

  // Effective clamp limit: zero or oversize screen means the full coordinate range.
  function automatic logic [CB:0] eff_limit(input logic [CFG_DATA_W-1:0] size);
    logic [CMP_W-1:0] s;
    logic [CMP_W-1:0] full;
    logic [CMP_W-1:0] r;
    s    = CMP_W'(size);
    full = CMP_W'(1) << CB;
    if (s == '0 || s > full) begin
      r = full;
    end else begin
      r = s;
    end
    return r[CB:0];
  endfunction

  function automatic logic [CB-1:0] clamp_pos(input logic signed [SW-1:0] v,
                                              input logic [CB:0] lim);
    logic [CB:0] lim_m1;
    lim_m1 = lim - {{CB{1'b0}}, 1'b1};
    if (v < 0) begin
      return '0;
    end else if (v >= $signed({1'b0, lim})) begin
      return lim_m1[CB-1:0];
    end else begin
      return v[CB-1:0];
    end
  endfunction

  // input register
  logic    s1_valid;
  pmd_in_t s1;

  // configuration and decoder state
  logic          enable;
  logic [CB:0]   lim_x;
  logic [CB:0]   lim_y;
  logic [1:0]    byte_count;
  logic [7:0]    header_byte;
  logic [7:0]    delta_x_byte;
  logic [CB-1:0] ptr_x;
  logic [CB-1:0] ptr_y;
  logic [2:0]    button_state;

  logic          ev_free;
  logic          proc;
  logic          active;
  logic          pkt_done;
  logic          cfg_we;
  logic [CB:0]   cfg_lim;
  logic [CB:0]   rst_lim_x;
  logic [CB:0]   rst_lim_y;

  logic signed [7:0]    dx;
  logic signed [7:0]    dy;
  logic                 moved;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic [CB-1:0]        new_x;
  logic [CB-1:0]        new_y;
  logic [CB-1:0]        ptr_x_next;
  logic [CB-1:0]        ptr_y_next;
  logic [2:0]           newb;
  logic [2:0]           changed;
  logic [EXT_W-1:0]     ext_x;
  logic [EXT_W-1:0]     ext_y;
  pmd_evset_t           load;

  // Configuration writes are always taken; software must write only while the block is idle; not enforced here.
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign cfg_lim   = eff_limit(cfg_data);
  assign rst_lim_x = eff_limit(RESET_SCREEN_WIDTH);
  assign rst_lim_y = eff_limit(RESET_SCREEN_HEIGHT);

  // Hold the byte in the input register until the serializer can take its events.
  assign in_stall = s1_valid && !ev_free;
  assign proc     = s1_valid && ev_free;
  assign active   = s1.from_aux && enable;
  assign pkt_done = proc && active && (byte_count == BC_DELTA_Y)
                    && ((header_byte & HDR_OVERFLOW) == 8'h00);

  // Decode: PS/2 Y grows upward, screen Y grows downward, so subtract it.
  assign dx    = $signed(delta_x_byte);
  assign dy    = $signed(s1.data_byte);
  assign moved = (dx != 8'sd0) || (dy != 8'sd0);
  assign sum_x = $signed({2'b00, ptr_x}) + SW'(dx);
  assign sum_y = $signed({2'b00, ptr_y}) - SW'(dy);
  assign new_x = clamp_pos(sum_x, lim_x);
  assign new_y = clamp_pos(sum_y, lim_y);
  assign ptr_x_next = moved ? new_x : ptr_x;
  assign ptr_y_next = moved ? new_y : ptr_y;

  assign newb    = header_byte[2:0] & HDR_BUTTONS[2:0];
  assign changed = newb ^ button_state;

  // Report positions on the 12-bit event fields.
  assign ext_x = EXT_W'(ptr_x_next);
  assign ext_y = EXT_W'(ptr_y_next);

  always_comb begin
    load.mask    = pkt_done ? {changed, moved} : 4'd0;
    load.buttons = newb;
    load.pos_x   = ext_x[POS_W-1:0];
    load.pos_y   = ext_y[POS_W-1:0];
  end

  // input register: advance when empty or when its byte is decoded this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (proc) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1 <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg_we && cfg_index == CFG_ENABLE) begin
      enable <= cfg_data[0];
    end
  end

  // Screen size and cursor: a size write recenters that axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim_x <= rst_lim_x;
      lim_y <= rst_lim_y;
      ptr_x <= rst_lim_x[CB:1];
      ptr_y <= rst_lim_y[CB:1];
    end else if (cfg_we && cfg_index == CFG_SCREEN_WIDTH) begin
      lim_x <= cfg_lim;
      ptr_x <= cfg_lim[CB:1];
    end else if (cfg_we && cfg_index == CFG_SCREEN_HEIGHT) begin
      lim_y <= cfg_lim;
      ptr_y <= cfg_lim[CB:1];
    end else if (pkt_done) begin
      ptr_x <= ptr_x_next;
      ptr_y <= ptr_y_next;
    end
  end

  // Packet assembly; drop a header without the sync bit to regain alignment.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= BC_HEADER;
      header_byte  <= 8'h00;
      delta_x_byte <= 8'h00;
      button_state <= 3'b000;
    end else if (proc && active) begin
      case (byte_count)
        BC_HEADER: begin
          if ((s1.data_byte & HDR_SYNC_BIT) != 8'h00) begin
            header_byte <= s1.data_byte;
            byte_count  <= BC_DELTA_X;
          end
        end
        BC_DELTA_X: begin
          delta_x_byte <= s1.data_byte;
          byte_count   <= BC_DELTA_Y;
        end
        default: begin
          byte_count <= BC_HEADER;
          if (pkt_done) begin
            button_state <= newb;
          end
        end
      endcase
    end
  end

  pmd_evt_ser u_ser (
    .clk        (clk),
    .rst        (rst),
    .load_valid (proc),
    .load       (load),
    .load_free  (ev_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    byte_count != 2'd3)
    else $error("packet byte count out of range");

  a_ptr_in: assert property (@(posedge clk) disable iff (rst)
    {1'b0, ptr_x} < lim_x && {1'b0, ptr_y} < lim_y)
    else $error("cursor outside screen");

  a_overflow_holds: assert property (@(posedge clk) disable iff (rst)
    proc && active && byte_count == BC_DELTA_Y
    && (header_byte & HDR_OVERFLOW) != 8'h00 && !cfg_we
    |=> ptr_x == $past(ptr_x) && button_state == $past(button_state))
    else $error("overflow packet changed state");

  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> s1_valid)
    else $error("transfer lost at input register");

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import pmd_pkg::*;

  localparam int                     CLK_HALF    = 5;
  localparam int                     CYCLE_LIMIT = 200000;
  localparam int                     COORD_SPAN  = 1 << POS_W;
  localparam logic [CFG_IDX_W-1:0]   CFG_UNUSED  = 2'd3;
  localparam int                     DRAIN_WAIT  = 4;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pmd_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  pmd_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow copy of the decoder: registers, packet assembly and cursor.
  logic                  mouse_enabled;
  logic [CFG_DATA_W-1:0] screen_w;
  logic [CFG_DATA_W-1:0] screen_h;
  logic [1:0]            bytes_held;
  logic [7:0]            held_header;
  logic [7:0]            held_dx;
  int                    ptr_x;
  int                    ptr_y;
  logic [2:0]            buttons_down;

  pmd_out_t pending_events[$];

  // Allow idle cycles on both channels while set.
  bit idle_on = 1'b1;

  int mismatches     = 0;
  int byte_transfers = 0;
  int decoded_bytes  = 0;
  int events_checked = 0;
  int reg_writes     = 0;
  int cycle_count    = 0;

  ps2_mouse_packet_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Zero or oversize screens fall back to the full coordinate range.
  function automatic int usable_size(logic [CFG_DATA_W-1:0] size);
    if (size == 0 || size > COORD_SPAN) begin
      return COORD_SPAN;
    end
    return int'(size);
  endfunction

  function automatic int clamp_coord(int v, int limit);
    if (v < 0) begin
      return 0;
    end
    if (v >= limit) begin
      return limit - 1;
    end
    return v;
  endfunction

  function automatic void reset_shadow();
    mouse_enabled = 1'b0;
    screen_w      = RESET_SCREEN_WIDTH;
    screen_h      = RESET_SCREEN_HEIGHT;
    bytes_held    = 2'd0;
    held_header   = 8'h00;
    held_dx       = 8'h00;
    ptr_x         = usable_size(screen_w) / 2;
    ptr_y         = usable_size(screen_h) / 2;
    buttons_down  = 3'b000;
  endfunction

  // Advance the shadow decoder by one transferred byte and queue the events it yields.
  function automatic void decode_mouse_byte(pmd_in_t item);
    pmd_out_t   packet_events[$];
    pmd_out_t   ev;
    logic [1:0] btn_code[3];
    logic [2:0] pkt_buttons;
    int         dx;
    int         dy;

    btn_code = '{BTN_LEFT, BTN_RIGHT, BTN_MIDDLE};
    if (!item.from_aux || !mouse_enabled) begin
      return;
    end
    decoded_bytes++;
    if (bytes_held == 2'd0) begin
      // Resync: a header candidate without the sync bit is dropped.
      if ((item.data_byte & HDR_SYNC_BIT) != 0) begin
        held_header = item.data_byte;
        bytes_held  = 2'd1;
      end
      return;
    end
    if (bytes_held == 2'd1) begin
      held_dx    = item.data_byte;
      bytes_held = 2'd2;
      return;
    end
    bytes_held = 2'd0;
    // Drop the whole packet on X or Y overflow.
    if ((held_header & HDR_OVERFLOW) != 0) begin
      return;
    end

    dx = $signed(held_dx);
    dy = $signed(item.data_byte);
    if (dx != 0 || dy != 0) begin
      ptr_x = clamp_coord(ptr_x + dx, usable_size(screen_w));
      ptr_y = clamp_coord(ptr_y - dy, usable_size(screen_h));
    end
    ev.pos_x = POS_W'(ptr_x);
    ev.pos_y = POS_W'(ptr_y);
    ev.last  = 1'b0;
    if (dx != 0 || dy != 0) begin
      ev.event_type = EV_MOVE;
      ev.button     = BTN_NONE;
      packet_events.push_back(ev);
    end

    pkt_buttons = held_header[2:0] & HDR_BUTTONS[2:0];
    for (int i = 0; i < 3; i++) begin
      if (buttons_down[i] != pkt_buttons[i]) begin
        ev.event_type = pkt_buttons[i] ? EV_DOWN : EV_UP;
        ev.button     = btn_code[i];
        packet_events.push_back(ev);
      end
    end
    buttons_down = pkt_buttons;

    if (packet_events.size() > 0) begin
      packet_events[packet_events.size() - 1].last = 1'b1;
    end
    foreach (packet_events[k]) begin
      pending_events.push_back(packet_events[k]);
    end
  endfunction

  // Drive out_stall and check each event transfer against the oldest expectation.
  always @(posedge clk) begin
    pmd_out_t exp_ev;

    out_stall <= idle_on && ($urandom_range(99) < 33);
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: type %0d button %0d x %0d y %0d last %0d",
               out_data.event_type, out_data.button, out_data.pos_x, out_data.pos_y,
               out_data.last);
        mismatches++;
      end else begin
        exp_ev = pending_events.pop_front();
        events_checked++;
        if (out_data.event_type !== exp_ev.event_type) begin
          $error("event_type: expected %0d, got %0d", exp_ev.event_type, out_data.event_type);
          mismatches++;
        end
        if (out_data.button !== exp_ev.button) begin
          $error("button: expected %0d, got %0d", exp_ev.button, out_data.button);
          mismatches++;
        end
        if (out_data.pos_x !== exp_ev.pos_x) begin
          $error("pos_x: expected %0d, got %0d", exp_ev.pos_x, out_data.pos_x);
          mismatches++;
        end
        if (out_data.pos_y !== exp_ev.pos_y) begin
          $error("pos_y: expected %0d, got %0d", exp_ev.pos_y, out_data.pos_y);
          mismatches++;
        end
        if (out_data.last !== exp_ev.last) begin
          $error("last: expected %0d, got %0d", exp_ev.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // Send one byte; valid stays high after the transfer until the next call or a drain.
  task automatic send_byte(input logic [7:0] value, input logic aux);
    if (idle_on && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_data  <= '{data_byte: value, from_aux: aux};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    byte_transfers++;
    decode_mouse_byte('{data_byte: value, from_aux: aux});
  endtask

  task automatic send_packet(input logic [7:0] header, input logic [7:0] dx,
                             input logic [7:0] dy);
    send_byte(header, 1'b1);
    send_byte(dx, 1'b1);
    send_byte(dy, 1'b1);
  endtask

  // Hold the input, wait for every queued event, then let the last byte leave the pipe.
  task automatic drain_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Registers change only while the decoder is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    drain_events();
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_ENABLE: begin
        mouse_enabled = value[0];
      end
      CFG_SCREEN_WIDTH: begin
        screen_w = value;
        ptr_x    = usable_size(value) / 2;
      end
      CFG_SCREEN_HEIGHT: begin
        screen_h = value;
        ptr_y    = usable_size(value) / 2;
      end
      default: begin
        // other indexes are ignored
      end
    endcase
  endtask

  // Bytes while disabled, keyboard bytes, resync, overflow, and all button edges.
  task automatic test_packet_basics();
    send_packet(8'h09, 8'h10, 8'h10);
    write_reg(CFG_ENABLE, 13'd1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // Full-scale deltas from the reset cursor with left going down.
    send_packet(8'h09, 8'h7F, 8'h80);
    send_packet(8'hC8, 8'h20, 8'h20);
    // No movement: left up, right and middle down.
    send_packet(8'h0E, 8'h00, 8'h00);
    send_packet(8'h08, 8'h80, 8'h7F);
  endtask

  // Screen extremes, recentering, clamping and the unused index.
  task automatic test_screen_limits();
    write_reg(CFG_SCREEN_WIDTH, 13'd1);
    write_reg(CFG_SCREEN_HEIGHT, 13'd1);
    send_packet(8'h09, 8'h7F, 8'h80);
    write_reg(CFG_SCREEN_WIDTH, 13'd4096);
    write_reg(CFG_SCREEN_HEIGHT, 13'd4096);
    send_packet(8'h08, 8'h80, 8'h7F);
    write_reg(CFG_SCREEN_WIDTH, 13'd0);
    write_reg(CFG_SCREEN_HEIGHT, 13'd8191);
    write_reg(CFG_UNUSED, 13'd8191);
    write_reg(CFG_SCREEN_WIDTH, 13'd3);
    write_reg(CFG_SCREEN_HEIGHT, 13'd2);
    send_packet(8'h0C, 8'h7F, 8'h7F);
    send_packet(8'h08, 8'h80, 8'h80);
  endtask

  // Disabling mid-packet keeps the assembled bytes.
  task automatic test_enable_mid_packet();
    send_byte(8'h0B, 1'b1);
    write_reg(CFG_ENABLE, 13'd0);
    send_byte(8'h55, 1'b1);
    write_reg(CFG_ENABLE, 13'd1);
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_screen_size();
    case ($urandom_range(9))
      0: return 13'd1;
      1: return 13'd2;
      2: return 13'($urandom_range(3, 40));
      3: return 13'd4096;
      4: return 13'd0;
      5: return 13'($urandom_range(4097, 8191));
      default: return 13'($urandom_range(1, 4096));
    endcase
  endfunction

  function automatic logic [7:0] pick_delta();
    logic [7:0] corner[5];

    corner = '{8'h7F, 8'h80, 8'h00, 8'h01, 8'hFF};
    case ($urandom_range(3))
      0, 1: return 8'($urandom_range(16)) - 8'd8;
      2: return 8'($urandom_range(255));
      default: return corner[$urandom_range(4)];
    endcase
  endfunction

  // Mostly well-formed packets with random content, plus noise and broken sequences.
  task automatic test_random_traffic(input int phases, input int bytes_per_phase);
    logic [7:0] header;
    int         start_count;

    for (int p = 0; p < phases; p++) begin
      // Run one phase without any idle cycles.
      idle_on = (p != 1);
      write_reg(CFG_SCREEN_WIDTH, pick_screen_size());
      write_reg(CFG_SCREEN_HEIGHT, pick_screen_size());
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_ENABLE, 13'd0);
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      write_reg(CFG_ENABLE, 13'(1 | ($urandom_range(1) << 12)));
      start_count = decoded_bytes;
      while (decoded_bytes - start_count < bytes_per_phase) begin
        case ($urandom_range(19))
          0, 1: begin
            send_byte(8'($urandom_range(255)) & ~HDR_SYNC_BIT, 1'b1);
          end
          2, 3: begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
          end
          default: begin
            header = {2'b00, 2'($urandom_range(3)), 1'b1, 3'($urandom_range(7))};
            if ($urandom_range(9) == 0) begin
              header[7:6] = 2'($urandom_range(1, 3));
            end
            send_byte(header, 1'b1);
            // Slip a keyboard byte into the packet now and then.
            if ($urandom_range(9) == 0) begin
              send_byte(8'($urandom_range(255)), 1'b0);
            end
            send_byte(pick_delta(), 1'b1);
            send_byte(pick_delta(), 1'b1);
          end
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    reset_shadow();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_packet_basics();
    test_screen_limits();
    test_enable_mid_packet();
    test_random_traffic(4, 36);

    // Drain the last events and let the pipe settle.
    drain_events();
    repeat (10) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d expected events never arrived", pending_events.size());
      mismatches++;
    end

    $display("Covered %0d byte transfers (%0d decoded) and %0d register writes,",
             byte_transfers, decoded_bytes, reg_writes);
    $display("checking %0d move and button events with %0d mismatches.",
             events_checked, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
